/* hdl/ptq_pkg.sv */
// ptq_pkg: shared types and codes for the priority task queue
// used by ptq_cell and priority_task_queue_dispatch_top; no dependencies
`default_nettype none

package ptq_pkg;

    // request kinds as carried in s_tuser
    localparam logic [1:0] REQ_INSERT   = 2'd0;
    localparam logic [1:0] REQ_CHANGE   = 2'd1;
    localparam logic [1:0] REQ_DISPATCH = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_NONE      = 2'd3;

    // operations broadcast to every cell of the row
    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_REMOVE = 2'd2;
    localparam logic [1:0] CELL_POP    = 2'd3;

    typedef struct packed {
        logic [15:0] task_id;
        logic [7:0]  prio;
        logic [15:0] exec_time;
    } entry_t;

    typedef struct packed {
        logic [1:0] op;
        entry_t     req;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* hdl/ptq_cell.sv */
// ptq_cell: one slot of the sorted queue, compare-and-shift against its neighbours
// depends on ptq_pkg
`default_nettype none

module ptq_cell
(
    input  wire                 clk,
    input  ptq_pkg::cell_ctrl_t ctrl,
    input  wire                 occ,
    input  ptq_pkg::entry_t     left_ent,
    input  wire                 left_ge,
    input  ptq_pkg::entry_t     right_ent,
    input  wire                 hit_in,
    output ptq_pkg::entry_t     ent,
    output logic                ge,
    output logic                hit_out,
    output logic [15:0]         match_time
);

    ptq_pkg::entry_t ent_reg;
    ptq_pkg::entry_t ent_next;
    logic            match;

    assign ent        = ent_reg;
    // occupied slot that must stay ahead of the new entry
    assign ge         = occ && (ent_reg.prio >= ctrl.req.prio);
    assign match      = occ && (ent_reg.task_id == ctrl.req.task_id);
    assign hit_out    = hit_in || match;
    // only the first matching slot contributes its time
    assign match_time = (match && !hit_in) ? ent_reg.exec_time : 16'd0;

    always_comb
    begin
        ent_next = ent_reg;
        case (ctrl.op)
            ptq_pkg::CELL_INSERT:
            begin
                if (!ge)
                begin
                    if (left_ge)
                    begin
                        ent_next = ctrl.req;
                    end
                    else
                    begin
                        ent_next = left_ent;
                    end
                end
            end
            ptq_pkg::CELL_REMOVE:
            begin
                if (hit_out)
                begin
                    ent_next = right_ent;
                end
            end
            ptq_pkg::CELL_POP:
            begin
                ent_next = right_ent;
            end
            default:
            begin
                ent_next = ent_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

/* hdl/priority_task_queue_dispatch_top.sv */
// priority_task_queue_dispatch_top: sorted task queue with dispatch onto cores
// depends on ptq_pkg and ptq_cell
//
// Usage
//   s_* stream: one request per transaction. s_tuser is the request kind
//   (insert, change priority, dispatch); s_tdata carries task id, priority
//   and execution time. m_* stream: results; m_tlast marks the final result
//   of a request. Insert and change give one result, dispatch gives one per
//   core assigned, or a single "nothing dispatched" result.
//   cfg_we/cfg_wdata write active_cores; write only while the block is idle.
// Operation
//   A request is registered when taken and worked on in S_EXEC. Change
//   priority is a remove pass, then an insert pass through the cell row.
//   One request is in flight at a time; the dispatch walk visits one core
//   a cycle, up to MAX_CORES, but waits at a free core while the output register is full.
// Reset
//   Queue empty, all cores free, active_cores = 8, no result pending.
// Stalls
//   A finished result sits in the output register; while m_tready is low
//   the next request is still taken but its work waits for the slot.
`default_nettype none

module priority_task_queue_dispatch_top
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_CORES   = 8
)
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [39:0] s_tdata,   // task_id[15:0], priority_req[23:16], exec_time[39:24]
    input  wire [1:0]  s_tuser,   // req_type[1:0]
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [39:0] m_tdata,  // status[1:0], core_id[5:2], out_task_id[21:6],
                                  // out_exec_time[37:22], zero fill[39:38]
    output logic [1:0] m_tuser,   // ack_kind[1:0]
    output logic       m_tlast,
    input  wire        cfg_we,
    input  wire [3:0]  cfg_wdata
);

    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CORE_W = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_EXEC    = 2'd1;
    localparam logic [1:0] S_CHG_INS = 2'd2;
    localparam logic [1:0] S_DISP    = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CORE_W-1:0]    core_cnt_reg, core_cnt_next;
    logic [MAX_CORES-1:0] core_busy_reg, core_busy_next;
    logic [3:0]           active_reg;

    logic [1:0]  req_kind_reg;
    logic [15:0] req_task_reg;
    logic [7:0]  req_pri_reg;
    logic [15:0] req_time_reg, req_time_next;

    logic        out_valid_reg;
    logic [1:0]  out_kind_reg, out_kind_next;
    logic [1:0]  out_status_reg, out_status_next;
    logic [3:0]  out_core_reg, out_core_next;
    logic [15:0] out_task_reg, out_task_next;
    logic [15:0] out_time_reg, out_time_next;
    logic        out_last_reg, out_last_next;
    logic        emit;
    logic        out_free;

    ptq_pkg::cell_ctrl_t  ctrl;
    logic [1:0]           cell_op;
    ptq_pkg::entry_t      ent [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] occ, ge, hit;
    logic [15:0]          match_time [QUEUE_DEPTH];
    logic [15:0]          keep_time;

    logic [MAX_CORES-1:0] free_now, beyond;
    logic                 any_free, cur_free, free_beyond, full, disp_last;

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_time_reg, out_task_reg, out_core_reg, out_status_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    assign ctrl.op            = cell_op;
    assign ctrl.req.task_id   = req_task_reg;
    assign ctrl.req.prio      = req_pri_reg;
    assign ctrl.req.exec_time = req_time_reg;

    // row of queue cells, slot 0 is the head
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            ptq_pkg::entry_t left_ent, right_ent;
            logic            left_ge, hit_in;

            assign occ[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign left_ent = ent[0];
                assign left_ge  = 1'b1;
                assign hit_in   = 1'b0;
            end
            else
            begin : g_body
                assign left_ent = ent[gi-1];
                assign left_ge  = ge[gi-1];
                assign hit_in   = hit[gi-1];
            end

            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_ent = ent[gi];
            end
            else
            begin : g_mid
                assign right_ent = ent[gi+1];
            end

            ptq_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .occ        (occ[gi]),
                .left_ent   (left_ent),
                .left_ge    (left_ge),
                .right_ent  (right_ent),
                .hit_in     (hit_in),
                .ent        (ent[gi]),
                .ge         (ge[gi]),
                .hit_out    (hit[gi]),
                .match_time (match_time[gi])
            );
        end
    endgenerate

    always_comb
    begin
        keep_time = 16'd0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            keep_time = keep_time | match_time[i];
        end
    end

    always_comb
    begin
        for (int j = 0; j < MAX_CORES; j++)
        begin
            free_now[j] = !core_busy_reg[j] && (8'(j) < {4'b0000, active_reg});
            beyond[j]   = (CORE_W'(j) > core_cnt_reg);
        end
    end

    assign any_free    = |free_now;
    assign cur_free    = free_now[core_cnt_reg];
    assign free_beyond = |(free_now & beyond);
    assign full        = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign disp_last   = (count_reg == CNT_W'(1)) || !free_beyond;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        core_cnt_next   = core_cnt_reg;
        core_busy_next  = core_busy_reg;
        req_time_next   = req_time_reg;
        cell_op         = ptq_pkg::CELL_HOLD;
        emit            = 1'b0;
        out_kind_next   = req_kind_reg;
        out_status_next = ptq_pkg::ST_OK;
        out_core_next   = 4'd0;
        out_task_next   = 16'd0;
        out_time_next   = 16'd0;
        out_last_next   = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next    = S_EXEC;
                    req_time_next = s_tdata[39:24];
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    case (req_kind_reg)
                        ptq_pkg::REQ_INSERT:
                        begin
                            emit       = 1'b1;
                            state_next = S_IDLE;
                            if (full)
                            begin
                                out_status_next = ptq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cell_op    = ptq_pkg::CELL_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ptq_pkg::REQ_CHANGE:
                        begin
                            if (!hit[QUEUE_DEPTH-1])
                            begin
                                emit            = 1'b1;
                                out_status_next = ptq_pkg::ST_NOT_FOUND;
                                state_next      = S_IDLE;
                            end
                            else
                            begin
                                // pull the entry out, keep its time for the reinsert
                                cell_op       = ptq_pkg::CELL_REMOVE;
                                count_next    = count_reg - CNT_W'(1);
                                req_time_next = keep_time;
                                state_next    = S_CHG_INS;
                            end
                        end
                        ptq_pkg::REQ_DISPATCH:
                        begin
                            if ((count_reg == '0) || !any_free)
                            begin
                                emit            = 1'b1;
                                out_status_next = ptq_pkg::ST_NONE;
                                state_next      = S_IDLE;
                            end
                            else
                            begin
                                core_cnt_next = '0;
                                state_next    = S_DISP;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CHG_INS:
            begin
                if (out_free)
                begin
                    cell_op    = ptq_pkg::CELL_INSERT;
                    count_next = count_reg + CNT_W'(1);
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_DISP:
            begin
                if (!cur_free)
                begin
                    core_cnt_next = core_cnt_reg + CORE_W'(1);
                end
                else if (out_free)
                begin
                    cell_op                      = ptq_pkg::CELL_POP;
                    count_next                   = count_reg - CNT_W'(1);
                    core_busy_next[core_cnt_reg] = 1'b1;
                    emit                         = 1'b1;
                    out_core_next                = 4'(32'(core_cnt_reg) + 32'd1);
                    out_task_next                = ent[0].task_id;
                    out_time_next                = ent[0].exec_time;
                    out_last_next                = disp_last;
                    if (disp_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        core_cnt_next = core_cnt_reg + CORE_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            core_cnt_reg  <= '0;
            core_busy_reg <= '0;
            active_reg    <= 4'd8;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            core_cnt_reg  <= core_cnt_next;
            core_busy_reg <= core_busy_next;
            if (cfg_we)
            begin
                active_reg <= cfg_wdata;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_time_reg <= req_time_next;
        if (s_tvalid && s_tready)
        begin
            req_kind_reg <= s_tuser;
            req_task_reg <= s_tdata[15:0];
            req_pri_reg  <= s_tdata[23:16];
        end
        if (emit)
        begin
            out_kind_reg   <= out_kind_next;
            out_status_reg <= out_status_next;
            out_core_reg   <= out_core_next;
            out_task_reg   <= out_task_next;
            out_time_reg   <= out_time_next;
            out_last_reg   <= out_last_next;
        end
    end

    // fill count never runs past the row
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    // no queue change while waiting for a request
    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> (count_reg == $past(count_reg)))
        else $error("queue count changed while idle");

    // an assigned core is never freed
    a_busy_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (($past(core_busy_reg) & ~core_busy_reg) == '0))
        else $error("busy core was freed");

    // insert and change always give a single, final result
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg != ptq_pkg::REQ_DISPATCH)) |-> out_last_reg)
        else $error("non-dispatch result without tlast");

endmodule

`default_nettype wire
